// ===== rtl/core/ansi_escape_stream_parser_macros.svh =====
// assertion macros shared by the parser checks
`ifndef ANSI_ESCAPE_STREAM_PARSER_MACROS_SVH
`define ANSI_ESCAPE_STREAM_PARSER_MACROS_SVH

// same-cycle implication, disabled in reset
`define AESP_ASSERT_IMP(label, rst, ante, cons) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: label failed");

// next-cycle implication, no disable
`define AESP_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("%m: label failed");

`endif

// ===== rtl/core/aesp_pkg.sv =====
// shared types and constants of the escape stream parser
package aesp_pkg;

   localparam logic [7:0] BYTE_ESC  = 8'h1b;
   localparam logic [7:0] BYTE_BSL  = 8'h5c;
   localparam logic [7:0] BYTE_CSI  = 8'h5b;
   localparam logic [7:0] BYTE_DCS  = 8'h50;
   localparam logic [7:0] BYTE_APC  = 8'h5f;
   localparam logic [7:0] FINAL_LO  = 8'h40;
   localparam logic [7:0] FINAL_HI  = 8'h7e;

   typedef enum logic [2:0] {
      MODE_TEXT = 3'd0,
      MODE_ESC  = 3'd1,
      MODE_CSI  = 3'd2,
      MODE_DCS  = 3'd3,
      MODE_APC  = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      K_TEXT      = 3'd0,
      K_CSI_BODY  = 3'd1,
      K_CSI_FINAL = 3'd2,
      K_DCS_BODY  = 3'd3,
      K_DCS_END   = 3'd4,
      K_APC_BODY  = 3'd5,
      K_APC_END   = 3'd6,
      K_BAD_ESC   = 3'd7
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_byte;
      logic       last;
   } rslt_type;

   typedef struct packed {
      logic [1:0] count;
      rslt_type   r0;
      rslt_type   r1;
      mode_type   mode_next;
      logic       held_next;
   } dec_type;

endpackage

// ===== rtl/core/aesp_dec.sv =====
// per-word decode: next parse mode and up to two results
module aesp_dec (
   input  aesp_pkg::mode_type mode,
   input  logic               held,
   input  logic [7:0]         in_byte,
   output aesp_pkg::dec_type  dec
);
   import aesp_pkg::*;

   kind_type body_kind;
   kind_type end_kind;

   always_comb begin
      body_kind = (mode == MODE_DCS) ? K_DCS_BODY : K_APC_BODY;
      end_kind  = (mode == MODE_DCS) ? K_DCS_END : K_APC_END;

      dec.count     = 2'd0;
      dec.r0        = '{kind: K_TEXT, out_byte: in_byte, last: 1'b0};
      dec.r1        = '{kind: body_kind, out_byte: in_byte, last: 1'b1};
      dec.mode_next = mode;
      dec.held_next = 1'b0;

      case (mode)
         MODE_ESC: begin
            if (in_byte == BYTE_CSI) begin
               dec.mode_next = MODE_CSI;
            end else if (in_byte == BYTE_DCS) begin
               dec.mode_next = MODE_DCS;
            end else if (in_byte == BYTE_APC) begin
               dec.mode_next = MODE_APC;
            end else begin
               dec.count     = 2'd1;
               dec.r0.kind   = K_BAD_ESC;
               dec.mode_next = MODE_TEXT;
            end
         end
         MODE_CSI: begin
            dec.count = 2'd1;
            if (in_byte >= FINAL_LO && in_byte <= FINAL_HI) begin
               dec.r0.kind   = K_CSI_FINAL;
               dec.mode_next = MODE_TEXT;
            end else begin
               dec.r0.kind = K_CSI_BODY;
            end
         end
         MODE_DCS, MODE_APC: begin
            if (held && in_byte == BYTE_BSL) begin
               dec.count     = 2'd1;
               dec.r0.kind   = end_kind;
               dec.mode_next = MODE_TEXT;
            end else if (held) begin
               // held esc goes out as body, new word follows unless it is esc
               dec.r0.kind     = body_kind;
               dec.r0.out_byte = BYTE_ESC;
               dec.held_next   = (in_byte == BYTE_ESC);
               dec.count       = (in_byte == BYTE_ESC) ? 2'd1 : 2'd2;
            end else if (in_byte == BYTE_ESC) begin
               dec.held_next = 1'b1;
            end else begin
               dec.count   = 2'd1;
               dec.r0.kind = body_kind;
            end
         end
         default: begin
            if (in_byte == BYTE_ESC) begin
               dec.mode_next = MODE_ESC;
            end else begin
               dec.count     = 2'd1;
               dec.r0.kind   = K_TEXT;
               dec.mode_next = MODE_TEXT;
            end
         end
      endcase

      dec.r0.last = (dec.count == 2'd1);
   end

endmodule

// ===== rtl/core/ansi_escape_stream_parser.sv =====
// escape stream parser top: input register, decode, three-entry result queue
// an accepted word is held in the input register, then decoded into the result queue once the queue has room
// throughput: one word per cycle while the result queue has room; a word with two results leaves as two results
// the result queue takes a decoded word only while it holds at most one result
// reset: synchronous, clears parse mode, held esc, input valid and queue count
module ansi_escape_stream_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);
   import aesp_pkg::*;

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   mode_type   mode_ff, mode_in;
   logic       held_ff, held_in;
   logic [1:0] cnt_ff, cnt_in;
   rslt_type   que_ff [3];
   rslt_type   que_in [3];

   dec_type    dec;
   logic       fire;
   logic       pop;
   logic [1:0] base;

   aesp_dec u_dec (
      .mode    (mode_ff),
      .held    (held_ff),
      .in_byte (in_byte_ff),
      .dec     (dec)
   );

   assign fire      = in_vld_ff && (cnt_ff <= 2'd1);
   assign req_ready = !in_vld_ff || fire;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign base      = cnt_ff - {1'b0, pop};

   assign rsp_kind     = que_ff[0].kind;
   assign rsp_out_byte = que_ff[0].out_byte;
   assign rsp_last     = que_ff[0].last;

   always_comb begin
      in_vld_in = req_ready ? req_valid : in_vld_ff;
      mode_in   = fire ? dec.mode_next : mode_ff;
      held_in   = fire ? dec.held_next : held_ff;
      cnt_in    = base + (fire ? dec.count : 2'd0);
      for (int i = 0; i < 3; i++) begin
         que_in[i] = (pop && i < 2) ? que_ff[(i < 2) ? i + 1 : i] : que_ff[i];
         if (fire && dec.count != 2'd0 && base == 2'(i)) begin
            que_in[i] = dec.r0;
         end
         if (fire && dec.count == 2'd2 && base + 2'd1 == 2'(i)) begin
            que_in[i] = dec.r1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         mode_ff   <= MODE_TEXT;
         held_ff   <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         in_vld_ff <= in_vld_in;
         mode_ff   <= mode_in;
         held_ff   <= held_in;
         cnt_ff    <= cnt_in;
      end
      if (req_ready) begin
         in_byte_ff <= req_in_byte;
      end
      que_ff <= que_in;
   end

endmodule

// ===== rtl/core/aesp_checker.sv =====
// port-level checks of the escape stream parser and their bind
`include "ansi_escape_stream_parser_macros.svh"

module aesp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_in_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_kind,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last
);
   import aesp_pkg::*;

   logic [11:0] rsp_word;
   logic        rsp_wait;
   logic        rsp_end;
   logic        rsp_final;
   logic        final_ok;

   assign rsp_word  = {rsp_kind, rsp_out_byte, rsp_last};
   assign rsp_wait  = rsp_valid && !rsp_ready;
   assign rsp_end   = rsp_valid && (rsp_kind == K_DCS_END || rsp_kind == K_APC_END);
   assign rsp_final = rsp_valid && rsp_kind == K_CSI_FINAL;
   assign final_ok  = rsp_out_byte >= FINAL_LO && rsp_out_byte <= FINAL_HI && rsp_last;

   `AESP_ASSERT_NXT(a_rst_no_rsp, reset, !rsp_valid)
   `AESP_ASSERT_NXT(a_rst_ready, reset, req_ready)
   `AESP_ASSERT_NXT(a_rsp_hold, !reset && rsp_wait, reset || (rsp_valid && $stable(rsp_word)))
   `AESP_ASSERT_IMP(a_end_bsl, reset, rsp_end, rsp_out_byte == BYTE_BSL && rsp_last)
   `AESP_ASSERT_IMP(a_final_rng, reset, rsp_final, final_ok)

endmodule

bind ansi_escape_stream_parser aesp_checker u_aesp_checker (.*);
